FILE: hdl/aes_ctr_pkg.sv
// shared types, constants and functions for the aes-128 counter mode payload cipher
package aes_ctr_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned BlkBytes  = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 64;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_HIGH      = 2'd0,
        REG_KEY_LOW       = 2'd1,
        REG_SESSION_NONCE = 2'd2,
        REG_NONCE_PREFIX  = 2'd3
    } cfg_reg_t;

    typedef logic [127:0] blk_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] payload;
    } lane_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // byte i of a block lives in bits 127-8i downto 120-8i
    function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
        get_byte = b[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic blk_t mix_cols(input blk_t s);
        blk_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8]  = a0 ^ all ^ gf_double(a0 ^ a1);
            t[119-32*c -: 8]  = a1 ^ all ^ gf_double(a1 ^ a2);
            t[111-32*c -: 8]  = a2 ^ all ^ gf_double(a2 ^ a3);
            t[103-32*c -: 8]  = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

    // next round key from previous one
    function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

FILE: hdl/aes_ctr_cell.sv
// one aes round cell: round function plus on-the-fly key step, registered
module aes_ctr_cell
    import aes_ctr_pkg::*;
#(
    parameter bit LastRound = 1'b0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [7:0] rcon,
    input  lane_ctl_t  ctl_in,
    input  blk_t       state_in,
    input  blk_t       key_in,
    output lane_ctl_t  ctl_out,
    output blk_t       state_out,
    output blk_t       key_out
);
    lane_ctl_t ctl_reg;
    blk_t      state_reg;
    blk_t      key_reg;
    blk_t      rk;
    blk_t      ss;

    always_comb begin
        rk = next_key(key_in, rcon);
        ss = sub_shift(state_in);
        if (!LastRound) begin
            ss = mix_cols(ss);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
        if (en) begin
            ctl_reg.payload <= ctl_in.payload;
            state_reg       <= ss ^ rk;
            key_reg         <= rk;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule

FILE: hdl/aes128_ctr_payload_cipher_unit.sv
// top level: config registers, counter block build, ten-cell round chain, output xor
// One payload word enters per cycle unless stalled; its result passes through an input
// register adding the first round key, then ten round cells, each with its own key step,
// and the result register feeding m_tdata. The whole chain advances together and stalls
// only when the result register is full and m_tready is low; configuration is sampled by
// the first stage, so write it only when the chain is empty.
module aes128_ctr_payload_cipher_unit
    import aes_ctr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [103:0]        s_tdata,   // role_id, frame_counter, payload_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata    // payload_out
);
    logic [63:0] key_high_reg, key_low_reg;
    logic [55:0] prefix_reg;
    logic [31:0] nonce_reg;
    logic        en;
    lane_ctl_t   ctl [0:NumRounds+1];
    blk_t        st  [0:NumRounds+1];
    blk_t        ky  [0:NumRounds+1];
    lane_ctl_t   ctl0_reg;
    blk_t        st0_reg, ky0_reg;
    blk_t        ctr_blk, key0;
    logic [7:0]  rc [0:NumRounds-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            nonce_reg    <= '0;
            prefix_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_KEY_HIGH:      key_high_reg <= cfg_wdata;
                REG_KEY_LOW:       key_low_reg  <= cfg_wdata;
                REG_SESSION_NONCE: nonce_reg    <= cfg_wdata[31:0];
                REG_NONCE_PREFIX:  prefix_reg   <= cfg_wdata[55:0];
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        key0    = {key_high_reg, key_low_reg};
        ctr_blk = {prefix_reg, nonce_reg, s_tdata[7:0], s_tdata[39:8]};
        rc[0]   = 8'h01;
        for (int i = 1; i < NumRounds; i++) begin
            rc[i] = gf_double(rc[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg.valid <= 1'b0;
        end else if (en) begin
            ctl0_reg.valid <= s_tvalid;
        end
        if (en) begin
            ctl0_reg.payload <= s_tdata[103:40];
            st0_reg          <= ctr_blk ^ key0;
            ky0_reg          <= key0;
        end
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;
    assign ky[0]  = ky0_reg;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_ctr_cell #(.LastRound(g == NumRounds-1)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .rcon      (rc[g]),
            .ctl_in    (ctl[g]),
            .state_in  (st[g]),
            .key_in    (ky[g]),
            .ctl_out   (ctl[g+1]),
            .state_out (st[g+1]),
            .key_out   (ky[g+1])
        );
    end

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] ks;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            ks[8*i +: 8] = get_byte(st[NumRounds], i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= ctl[NumRounds].valid;
        end
        if (en) begin
            out_data_reg <= ctl[NumRounds].payload ^ ks;
        end
    end

    assign ctl[NumRounds+1] = '{valid: out_valid_reg, payload: out_data_reg};
    assign st[NumRounds+1]  = '0;
    assign ky[NumRounds+1]  = '0;
    assign m_tvalid         = ctl[NumRounds+1].valid;
    assign m_tdata          = ctl[NumRounds+1].payload;

    property p_stall_holds;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_stall_holds: assert property (p_stall_holds) else $error("result changed under stall");

    property p_ready_when_empty;
        @(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready;
    endproperty
    a_ready_when_empty: assert property (p_ready_when_empty) else $error("stalled while empty");

    property p_first_stage;
        @(posedge aclk) disable iff (!aresetn)
            (s_tvalid && s_tready) |=> ctl[0].valid;
    endproperty
    a_first_stage: assert property (p_first_stage) else $error("accepted word lost");
endmodule
